// File: rtl/core/muid_pkg.sv
// muid_pkg: shared types and codes of the multiply-slot instruction decoder
package muid_pkg;

  // register classes
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_S    = 2'd1,
    CLS_V    = 2'd2,
    CLS_P    = 2'd3
  } muid_cls_t;

  // special register read bits
  localparam logic [4:0] SR_NONE    = 5'h00;
  localparam logic [4:0] SR_ACSHIFT = 5'h01;
  localparam logic [4:0] SR_SVSHIFT = 5'h02;
  localparam logic [4:0] SR_RU      = 5'h04;
  localparam logic [4:0] SR_RV      = 5'h08;
  localparam logic [4:0] SR_UVCTL   = 5'h10;

  // long form opcodes (byte two, bits 3:0)
  localparam logic [3:0] OP_MUL_IMM_ACC = 4'd0;
  localparam logic [3:0] OP_MUL_RSHIFT  = 4'd1;
  localparam logic [3:0] OP_MUL_SCALAR  = 4'd2;
  localparam logic [3:0] OP_ILLEGAL     = 4'd3;
  localparam logic [3:0] OP_MUL_SV_LAST = 4'd7;
  localparam logic [3:0] OP_MUL_P_LAST  = 4'd11;
  localparam logic [3:0] OP_DOTP_S      = 4'd12;
  localparam logic [3:0] OP_DOTP_V      = 4'd13;
  localparam logic [3:0] OP_ADDM        = 4'd14;

  // vector sub-forms inside the mul_sv / mul_p groups
  localparam logic [1:0] SUB_SCALAR = 2'd0;
  localparam logic [1:0] SUB_RU     = 2'd1;
  localparam logic [1:0] SUB_VECTOR = 2'd3;

  // handler codes
  localparam logic [4:0] HC_SHORT_SV    = 5'd0;
  localparam logic [4:0] HC_SHORT_S     = 5'd1;
  localparam logic [4:0] HC_MUL_IMM_R   = 5'd2;
  localparam logic [4:0] HC_MUL_ACSH    = 5'd1;
  localparam logic [4:0] HC_RS_ACSH     = 5'd4;
  localparam logic [4:0] HC_RS_REG      = 5'd5;
  localparam logic [4:0] HC_SC_REG      = 5'd6;
  localparam logic [4:0] HC_SC_IMM_R    = 5'd7;
  localparam logic [4:0] HC_SV_BASE     = 5'd9;
  localparam logic [4:0] HC_P_BASE      = 5'd16;
  localparam logic [4:0] HC_SV_LAST_REG = 5'd0;
  localparam logic [4:0] HC_DOTP_S      = 5'd24;
  localparam logic [4:0] HC_DOTP_V      = 5'd26;
  localparam logic [4:0] HC_ADDM        = 5'd28;
  localparam logic [4:0] HC_SUBM        = 5'd29;

  // one decoded result beat
  typedef struct packed {
    logic       valid_res;
    logic [4:0] handler_code;
    logic [4:0] src1_reg;
    logic [4:0] src2_reg;
    logic [4:0] dest_reg;
    logic [6:0] shift_info;
    muid_cls_t  read_class_a;
    muid_cls_t  read_class_b;
    logic       reads_shift_scalar;
    muid_cls_t  write_class;
    logic [4:0] special_reads;
    logic       writes_mv;
  } muid_res_t;

endpackage

// File: rtl/core/muid_decode.sv
// muid_decode: combinational decode of one multiply-slot instruction
module muid_decode (
  input  logic              [31:0] instr_word,
  input  logic                     is_long,
  output muid_pkg::muid_res_t      res
);
  import muid_pkg::*;

  logic [7:0] b0, b1, b3;
  logic [3:0] op;
  logic [4:0] fa, fb, fl;
  logic [6:0] f7;
  logic [6:0] f7_neg;
  logic [1:0] f60;
  logic       imm;
  logic [1:0] sub;
  muid_cls_t  grp_cls;
  logic [4:0] grp_code;

  // instruction fields
  assign b0     = instr_word[31:24];
  assign b1     = instr_word[23:16];
  assign op     = instr_word[11:8];
  assign b3     = instr_word[7:0];
  assign fa     = {b0[1:0], b1[7:5]};
  assign fb     = b1[4:0];
  assign fl     = b3[4:0];
  assign f7     = b3[6:0];
  assign f7_neg = 7'(7'd0 - f7);
  assign f60    = b3[6:5];
  assign imm    = b3[7];
  assign sub    = op[1:0];

  // mul_sv / mul_p group class and handler code
  assign grp_cls  = (op <= OP_MUL_SV_LAST) ? CLS_V : CLS_P;
  assign grp_code = ((op <= OP_MUL_SV_LAST) ? HC_SV_BASE : HC_P_BASE)
                    + {2'b00, sub, 1'b0} + {4'b0000, ~imm};

  // decode
  always_comb begin
    res                    = '0;
    res.valid_res          = 1'b1;
    res.read_class_a       = CLS_NONE;
    res.read_class_b       = CLS_NONE;
    res.write_class        = CLS_NONE;
    if (!is_long) begin
      if (b0[2]) begin
        res.handler_code  = HC_SHORT_SV;
        res.src1_reg      = fb & 5'h1C;
        res.src2_reg      = fa & 5'h1C;
        res.dest_reg      = fa & 5'h1C;
        res.read_class_a  = CLS_V;
        res.read_class_b  = CLS_V;
        res.write_class   = CLS_V;
        res.special_reads = SR_SVSHIFT;
      end else begin
        res.handler_code  = HC_SHORT_S;
        res.src1_reg      = fb;
        res.src2_reg      = fa;
        res.dest_reg      = fa;
        res.read_class_a  = CLS_S;
        res.read_class_b  = CLS_S;
        res.write_class   = CLS_S;
        res.special_reads = SR_ACSHIFT;
        res.writes_mv     = 1'b1;
      end
    end else if (op <= OP_MUL_SCALAR) begin
      // scalar mul family
      res.src1_reg     = fb;
      res.src2_reg     = fa;
      res.write_class  = CLS_S;
      res.writes_mv    = 1'b1;
      res.read_class_a = CLS_S;
      if (op == OP_MUL_IMM_ACC) begin
        res.read_class_b = CLS_S;
        if (imm) begin
          res.dest_reg     = fa;
          res.handler_code = HC_MUL_IMM_R + {4'b0000, f7[6]};
          res.shift_info   = f7[6] ? f7_neg : f7;
        end else begin
          res.handler_code  = HC_MUL_ACSH;
          res.dest_reg      = fl;
          res.special_reads = SR_ACSHIFT;
        end
      end else if (op == OP_MUL_RSHIFT) begin
        if (imm) begin
          res.handler_code  = HC_RS_ACSH;
          res.dest_reg      = fl;
          res.special_reads = SR_ACSHIFT;
        end else begin
          res.handler_code       = HC_RS_REG;
          res.dest_reg           = fa;
          res.shift_info         = {2'b00, fl};
          res.read_class_b       = CLS_S;
          res.reads_shift_scalar = 1'b1;
        end
      end else begin
        res.dest_reg = fa;
        if (imm) begin
          res.handler_code       = HC_SC_REG;
          res.shift_info         = {2'b00, fl};
          res.reads_shift_scalar = 1'b1;
        end else begin
          res.handler_code = HC_SC_IMM_R + {4'b0000, f7[6]};
          res.shift_info   = f7[6] ? f7_neg : f7;
        end
      end
    end else if (op == OP_ILLEGAL) begin
      res.valid_res = 1'b0;
    end else if (op <= OP_MUL_P_LAST) begin
      // mul_sv and mul_p
      res.dest_reg    = fl & 5'h1C;
      res.write_class = grp_cls;
      if (sub == SUB_SCALAR) begin
        res.src1_reg     = fa;
        res.src2_reg     = fb & 5'h1C;
        res.read_class_a = CLS_S;
        res.read_class_b = grp_cls;
      end else if (sub == SUB_VECTOR) begin
        res.src1_reg     = fb & 5'h1C;
        res.src2_reg     = fa & 5'h1C;
        res.read_class_a = grp_cls;
        res.read_class_b = grp_cls;
      end else begin
        res.src2_reg      = fa & 5'h1C;
        res.read_class_a  = grp_cls;
        res.special_reads = SR_UVCTL | ((sub == SUB_RU) ? SR_RU : SR_RV);
      end
      if (imm) begin
        res.shift_info = {5'b00000, f60};
      end else begin
        res.special_reads = res.special_reads | SR_SVSHIFT;
      end
      res.handler_code = (op == OP_MUL_SV_LAST && !imm) ? HC_SV_LAST_REG : grp_code;
    end else if (op <= OP_DOTP_V) begin
      // dot products
      res.src2_reg     = fb & 5'h1C;
      res.dest_reg     = fl;
      res.read_class_b = CLS_V;
      res.write_class  = CLS_S;
      if (op == OP_DOTP_S) begin
        res.src1_reg     = fa;
        res.read_class_a = CLS_S;
        res.handler_code = HC_DOTP_S + {4'b0000, ~imm};
      end else begin
        res.src1_reg     = fa & 5'h1C;
        res.read_class_a = CLS_V;
        res.handler_code = HC_DOTP_V + {4'b0000, ~imm};
      end
      if (imm) begin
        res.shift_info = {5'b00000, f60};
      end else begin
        res.special_reads = SR_SVSHIFT;
      end
    end else begin
      // addm / subm
      res.handler_code = (op == OP_ADDM) ? HC_ADDM : HC_SUBM;
      res.src1_reg     = fa;
      res.src2_reg     = fb;
      res.dest_reg     = fl;
      res.read_class_a = CLS_S;
      res.read_class_b = CLS_S;
      res.write_class  = CLS_S;
    end
  end

endmodule

// File: rtl/core/multiply_unit_instruction_decoder.sv
// multiply_unit_instruction_decoder: registered multiply-slot decoder, top level
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   instr_word, is_long
//   out_     output     out_valid/out_stall decoded fields, one beat per input beat
//
// one beat accepted per cycle while in_stall is low; a beat's result is registered
// on its way to the out_ channel
// (input register, decode logic, result register)
// two beats can be in flight; in_stall rises only when both registers are full
// and out_stall is high
// synchronous active-low reset empties both registers; payload is not reset
module multiply_unit_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instr_word,
  input  logic        in_is_long,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [4:0]  out_handler_code,
  output logic [4:0]  out_src1_reg,
  output logic [4:0]  out_src2_reg,
  output logic [4:0]  out_dest_reg,
  output logic [6:0]  out_shift_info,
  output logic [1:0]  out_read_class_a,
  output logic [1:0]  out_read_class_b,
  output logic        out_reads_shift_scalar,
  output logic [1:0]  out_write_class,
  output logic [4:0]  out_special_reads,
  output logic        out_writes_mv
);
  import muid_pkg::*;

  logic        s1_v_r, s1_v_nxt;
  logic [31:0] s1_word_r;
  logic        s1_long_r;
  logic        out_v_r, out_v_nxt;
  muid_res_t   res_r;
  muid_res_t   dec_res;
  logic        out_adv;
  logic        s1_load;

  // stage advance
  assign out_adv  = !out_v_r || !out_stall;
  assign in_stall = s1_v_r && !out_adv;
  assign s1_load  = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_load) begin
      s1_v_nxt = 1'b1;
    end else if (out_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_adv) begin
      out_v_nxt = s1_v_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_instr_word;
      s1_long_r <= in_is_long;
    end
  end

  muid_decode u_decode (
    .instr_word (s1_word_r),
    .is_long    (s1_long_r),
    .res        (dec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      res_r <= dec_res;
    end
  end

  // outputs
  assign out_valid              = out_v_r;
  assign out_valid_res          = res_r.valid_res;
  assign out_handler_code       = res_r.handler_code;
  assign out_src1_reg           = res_r.src1_reg;
  assign out_src2_reg           = res_r.src2_reg;
  assign out_dest_reg           = res_r.dest_reg;
  assign out_shift_info         = res_r.shift_info;
  assign out_read_class_a       = res_r.read_class_a;
  assign out_read_class_b       = res_r.read_class_b;
  assign out_reads_shift_scalar = res_r.reads_shift_scalar;
  assign out_write_class        = res_r.write_class;
  assign out_special_reads      = res_r.special_reads;
  assign out_writes_mv          = res_r.writes_mv;

  // illegal opcode carries an all-zero result
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !res_r.valid_res) |->
      (res_r.handler_code == 5'd0 && res_r.dest_reg == 5'd0 &&
       res_r.write_class == CLS_NONE && res_r.special_reads == SR_NONE &&
       res_r.writes_mv == 1'b0))
    else $error("illegal opcode beat with nonzero fields");

  // every legal instruction writes some register
  a_legal_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.valid_res) |-> (res_r.write_class != CLS_NONE))
    else $error("legal beat with no destination class");

  // vector and pixel destinations are quad aligned
  a_quad_dest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.write_class == CLS_V || res_r.write_class == CLS_P)) |->
      (res_r.dest_reg[1:0] == 2'b00))
    else $error("misaligned vector destination");

  // stall only when the input register holds a beat
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with empty stage");

  // a beat in the input register moves on when the result side frees up
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && (!out_v_r || !out_stall)) |=> out_v_r)
    else $error("decoded beat lost");

endmodule
